/* src/m3i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and width helpers for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // cofactor k = a[CA]*a[CB] - a[CC]*a[CD], entries in row-major order
  localparam logic [3:0] CA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] CB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] CC [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] CD [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // exact cofactor width
  function automatic int cof_width(input int w);
    return 2 * w + 1;
  endfunction

  // determinant width, also large enough for the unit divisor of a singular matrix
  function automatic int det_width(input int w, input int f);
    return (3 * w + 3 > 3 * f + 1) ? 3 * w + 3 : 3 * f + 1;
  endfunction

  // divider remainder width
  function automatic int rem_width(input int w, input int f);
    int nw;
    int dw;
    nw = cof_width(w) + 2 * f;
    dw = det_width(w, f) + w;
    return (nw > dw) ? nw : dw;
  endfunction

  // front to back packet width: nine cofactors, divisor magnitude, sign, singular
  function automatic int pkt_width(input int w, input int f);
    return 9 * cof_width(w) + det_width(w, f) + 2;
  endfunction

endpackage
`default_nettype wire

/* src/m3i_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_fifo
// Two-entry queue between the front and the back of the inverse core.
// ----------------------------------------------------------------------------
module m3i_fifo import m3i_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_stall,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_stall,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");

endmodule
`default_nettype wire

/* src/m3i_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_front
// Accepts matrices, forms cofactors and determinant, flags singular ones.
// ----------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] a_in [9],
  output logic                              push_valid,
  input  wire logic                         push_stall,
  output logic [pkt_width(DATA_WIDTH, FRAC_BITS)-1:0] packet
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = cof_width(DATA_WIDTH);
  localparam int DW = det_width(DATA_WIDTH, FRAC_BITS);
  localparam int NS = 7;

  logic [NS-1:0]         v;
  logic                  en;
  logic signed [W-1:0]   a0 [9];
  logic signed [2*W-1:0] p1 [18];
  logic signed [W-1:0]   c1 [3];
  logic signed [W-1:0]   c2 [3];
  logic signed [CW-1:0]  cof2 [9];
  logic signed [CW-1:0]  cof3 [9];
  logic signed [CW-1:0]  cof4 [9];
  logic signed [CW-1:0]  cof5 [9];
  logic signed [CW-1:0]  cof6 [9];
  logic signed [2*W:0]   pl3 [3];
  logic signed [2*W:0]   ph3 [3];
  logic signed [DW-1:0]  t4 [3];
  logic signed [DW-1:0]  det5;
  logic                  sing6;
  logic                  dneg6;
  logic [DW-1:0]         dmag6;

  assign en         = !(v[NS-1] && push_stall);
  assign in_stall   = !en;
  assign push_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= a_in;
      for (int k = 0; k < 9; k++) begin
        p1[2*k]   <= a0[CA[k]] * a0[CB[k]];
        p1[2*k+1] <= a0[CC[k]] * a0[CD[k]];
      end
      for (int i = 0; i < 3; i++) begin
        c1[i] <= a0[3*i];
      end
      for (int k = 0; k < 9; k++) begin
        cof2[k] <= {p1[2*k][2*W-1], p1[2*k]} - {p1[2*k+1][2*W-1], p1[2*k+1]};
      end
      c2 <= c1;
      // first column times its cofactors, split into low and high halves
      for (int i = 0; i < 3; i++) begin
        pl3[i] <= c2[i] * $signed({1'b0, cof2[3*i][W-1:0]});
        ph3[i] <= c2[i] * $signed(cof2[3*i][CW-1:W]);
      end
      cof3 <= cof2;
      for (int i = 0; i < 3; i++) begin
        t4[i] <= (DW'(ph3[i]) <<< W) + DW'(pl3[i]);
      end
      cof4 <= cof3;
      det5 <= t4[0] + t4[1] + t4[2];
      cof5 <= cof4;
      sing6 <= (det5 == '0);
      dneg6 <= det5[DW-1];
      if (det5 == '0) begin
        dmag6 <= DW'(1) << (3 * FRAC_BITS);
      end else if (det5[DW-1]) begin
        dmag6 <= DW'(-det5);
      end else begin
        dmag6 <= DW'(det5);
      end
      cof6 <= cof5;
    end
  end

  always_comb begin
    packet = '0;
    for (int n = 0; n < 9; n++) begin
      packet[n*CW +: CW] = cof6[n];
    end
    packet[9*CW +: DW] = dmag6;
    packet[9*CW+DW]    = dneg6;
    packet[9*CW+DW+1]  = sing6;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && push_stall |=> v[NS-1] && $stable(sing6) && $stable(dmag6))
    else $error("front result changed while the queue was full");

endmodule
`default_nettype wire

/* src/m3i_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_div
// One result entry: pipelined restoring division with saturation.
// ----------------------------------------------------------------------------
module m3i_div import m3i_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic signed [cof_width(DATA_WIDTH)-1:0]       cof,
  input  wire logic [det_width(DATA_WIDTH, FRAC_BITS)-1:0]   den_mag,
  input  wire logic                                          den_neg,
  output logic [DATA_WIDTH-1:0]                              res,
  output logic                                               sat
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = cof_width(DATA_WIDTH);
  localparam int DW = det_width(DATA_WIDTH, FRAC_BITS);
  localparam int XW = rem_width(DATA_WIDTH, FRAC_BITS);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] cof_mag;
  logic [XW-1:0] nm0;
  logic [DW-1:0] dm0;
  logic          neg0;
  logic [XW-1:0] rem_r [1:W+1];
  logic [DW-1:0] dm_r  [1:W+1];
  logic [W-1:0]  q_r   [1:W+1];
  logic          neg_r [1:W+1];
  logic          ovf_r [1:W+1];
  logic [W-1:0]  q_f;
  logic [W-1:0]  res_next;
  logic          sat_next;

  assign cof_mag = cof[CW-1] ? CW'(-cof) : CW'(cof);

  always_ff @(posedge clk) begin
    if (en) begin
      nm0      <= XW'(cof_mag) << (2 * FRAC_BITS);
      dm0      <= den_mag;
      neg0     <= cof[CW-1] ^ den_neg;
      // quotient too large for W bits
      ovf_r[1] <= nm0 >= (XW'(dm0) << W);
      rem_r[1] <= nm0;
      dm_r[1]  <= dm0;
      q_r[1]   <= '0;
      neg_r[1] <= neg0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_bit
    logic [XW-1:0] trial;
    logic          ge;
    assign trial = XW'(dm_r[k+1]) << (W - 1 - k);
    assign ge    = rem_r[k+1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+2] <= ge ? rem_r[k+1] - trial : rem_r[k+1];
        q_r[k+2]   <= q_r[k+1] | (W'(ge) << (W - 1 - k));
        dm_r[k+2]  <= dm_r[k+1];
        neg_r[k+2] <= neg_r[k+1];
        ovf_r[k+2] <= ovf_r[k+1];
      end
    end
  end

  assign q_f = q_r[W+1];

  always_comb begin
    priority if (ovf_r[W+1]) begin
      sat_next = 1'b1;
      res_next = neg_r[W+1] ? MINV : MAXV;
    end else if (!neg_r[W+1] && q_f[W-1]) begin
      sat_next = 1'b1;
      res_next = MAXV;
    end else if (neg_r[W+1] && q_f[W-1] && (|q_f[W-2:0])) begin
      sat_next = 1'b1;
      res_next = MINV;
    end else begin
      sat_next = 1'b0;
      res_next = neg_r[W+1] ? -q_f : q_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      sat <= sat_next;
    end
  end

endmodule
`default_nettype wire

/* src/m3i_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_back
// Divides the transposed cofactors by the determinant, nine lanes wide.
// ----------------------------------------------------------------------------
module m3i_back import m3i_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        pop_valid,
  output logic                                             pop_stall,
  input  wire logic [pkt_width(DATA_WIDTH, FRAC_BITS)-1:0] packet,
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output logic [DATA_WIDTH-1:0]                            res [9],
  output logic                                             singular,
  output logic                                             saturated
);

  localparam int CW  = cof_width(DATA_WIDTH);
  localparam int DW  = det_width(DATA_WIDTH, FRAC_BITS);
  localparam int LAT = DATA_WIDTH + 3;

  logic [LAT-1:0] v;
  logic [LAT-1:0] sg;
  logic           en;
  logic [8:0]     sat;
  logic [DW-1:0]  den_mag;
  logic           den_neg;

  assign en        = !(v[LAT-1] && out_stall);
  assign pop_stall = !en;
  assign out_valid = v[LAT-1];
  assign singular  = sg[LAT-1];
  assign saturated = |sat;
  assign den_mag   = packet[9*CW +: DW];
  assign den_neg   = packet[9*CW+DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) sg <= {sg[LAT-2:0], packet[9*CW+DW+1]};
  end

  // entry (i,j) of the inverse takes cofactor (j,i)
  for (genvar n = 0; n < 9; n++) begin : g_lane
    m3i_div #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .en     (en),
      .cof    ($signed(packet[((n % 3) * 3 + n / 3) * CW +: CW])),
      .den_mag(den_mag),
      .den_neg(den_neg),
      .res    (res[n]),
      .sat    (sat[n])
    );
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(saturated) && $stable(singular))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

/* src/matrix3_inverse_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a 3x3 signed fixed-point matrix through its adjugate.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with nine entries in_r1c1..in_r3c3;
// a matrix transfers at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the nine inverse entries,
// singular (determinant zero, adjugate returned unscaled)
// and saturated (some entry clamped).
// Throughput is one matrix per cycle while the receiver does not stall. The
// path has seven front stages for products, cofactors and determinant,
// the two-entry queue, and DATA_WIDTH + 3 back stages for the
// one-bit-per-stage restoring dividers.
// When the receiver stalls, the back pipeline holds its result, the queue
// fills, and then the front holds and raises in_stall.
// Synchronous reset empties all stages and the queue.
// ----------------------------------------------------------------------------
module matrix3_inverse_core import m3i_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_r1c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_r1c2,
  input  wire logic signed [DATA_WIDTH-1:0] in_r1c3,
  input  wire logic signed [DATA_WIDTH-1:0] in_r2c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_r2c2,
  input  wire logic signed [DATA_WIDTH-1:0] in_r2c3,
  input  wire logic signed [DATA_WIDTH-1:0] in_r3c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_r3c2,
  input  wire logic signed [DATA_WIDTH-1:0] in_r3c3,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_r1c1,
  output logic signed [DATA_WIDTH-1:0]      out_r1c2,
  output logic signed [DATA_WIDTH-1:0]      out_r1c3,
  output logic signed [DATA_WIDTH-1:0]      out_r2c1,
  output logic signed [DATA_WIDTH-1:0]      out_r2c2,
  output logic signed [DATA_WIDTH-1:0]      out_r2c3,
  output logic signed [DATA_WIDTH-1:0]      out_r3c1,
  output logic signed [DATA_WIDTH-1:0]      out_r3c2,
  output logic signed [DATA_WIDTH-1:0]      out_r3c3,
  output logic                              singular,
  output logic                              saturated
);

  localparam int PW = pkt_width(DATA_WIDTH, FRAC_BITS);

  logic signed [DATA_WIDTH-1:0] a_in [9];
  logic [DATA_WIDTH-1:0]        res [9];
  logic                         push_valid;
  logic                         push_stall;
  logic [PW-1:0]                push_data;
  logic                         pop_valid;
  logic                         pop_stall;
  logic [PW-1:0]                pop_data;

  assign a_in = '{in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
                  in_r3c1, in_r3c2, in_r3c3};

  m3i_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_in      (a_in),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .packet    (push_data)
  );

  m3i_fifo #(
    .WIDTH(PW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data)
  );

  m3i_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_stall(pop_stall),
    .packet   (pop_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res      (res),
    .singular (singular),
    .saturated(saturated)
  );

  assign out_r1c1 = $signed(res[0]);
  assign out_r1c2 = $signed(res[1]);
  assign out_r1c3 = $signed(res[2]);
  assign out_r2c1 = $signed(res[3]);
  assign out_r2c2 = $signed(res[4]);
  assign out_r2c3 = $signed(res[5]);
  assign out_r3c1 = $signed(res[6]);
  assign out_r3c2 = $signed(res[7]);
  assign out_r3c3 = $signed(res[8]);

endmodule
`default_nettype wire
